// File: hw/rtl/svfs_pkg.sv
// svfs_pkg: types and constants shared by the staged valve fill sequencer.
// Holds the word, config and state structs plus the fixed tick counts.
// No dependencies.
package svfs_pkg;

  // Fixed tick counts
  localparam logic [6:0] SETTLE_TICKS   = 7'd80;
  localparam logic [4:0] ACT_HOLD_TICKS = 5'd10;
  localparam logic [4:0] SOL_HOLD_TICKS = 5'd20;
  localparam logic [5:0] UNIT_TICKS     = 6'd40;
  localparam logic [4:0] PULSE_TICKS    = 5'd25;
  localparam logic [5:0] SLOW_MAX       = 6'd63;
  localparam logic [7:0] UNITS_MAX      = 8'd255;

  // Valve drive bits
  localparam logic [2:0] VALVE_NONE = 3'b000;
  localparam logic [2:0] VALVE_LOW  = 3'b001;
  localparam logic [2:0] VALVE_MED  = 3'b010;
  localparam logic [2:0] VALVE_HIGH = 3'b100;
  localparam logic [2:0] VALVE_ALL  = 3'b111;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAGE1_THR   = 3'd0,
    CFG_STAGE2_THR   = 3'd1,
    CFG_STAGE3_THR   = 3'd2,
    CFG_CUTOFF_EN    = 3'd3,
    CFG_CUTOFF_THR   = 3'd4,
    CFG_WAIT_LIMIT   = 3'd5,
    CFG_NOFLOW_LIMIT = 3'd6,
    CFG_ACT_MODE     = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_EXCESS     = 3'd1,
    CAUSE_WAIT       = 3'd2,
    CAUSE_NO_FLOW    = 3'd3,
    CAUSE_SWITCH_OFF = 3'd4
  } end_cause_t;

  typedef struct packed {
    logic [15:0] stage1_threshold;
    logic [15:0] stage2_threshold;
    logic [15:0] stage3_threshold;
    logic        cutoff_enable;
    logic [15:0] cutoff_threshold;
    logic [7:0]  wait_limit;
    logic [7:0]  no_flow_limit;
    logic        actuator_mode;
  } svfs_cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        switch_on;
    logic [15:0] measured_period;
    logic        flow_established;
    logic        flow_pulse_seen;
    logic        counter_request;
  } svfs_item_t;

  typedef struct packed {
    logic       low_valve_on;
    logic       med_valve_on;
    logic       high_valve_on;
    logic [1:0] fill_stage;
    logic       fill_active;
    logic [2:0] end_cause;
    logic       counter_drive;
    logic       pulse_watch_enable;
  } svfs_result_t;

  typedef struct packed {
    logic [1:0] stage;
    logic       running;
    logic       established;
    logic [2:0] valve;
    logic [6:0] settle_count;
    logic       settle_done;
    logic [4:0] hold_count;
    logic [5:0] tick_count;
    logic [5:0] slow_count;
    logic [7:0] wait_units;
    logic [5:0] excess_count;
    logic       watch_active;
    logic [5:0] watch_ticks;
    logic [7:0] watch_units;
    logic       pulse_active;
    logic [4:0] pulse_ticks;
    end_cause_t cause;
  } svfs_state_t;

  localparam svfs_state_t STATE_RESET = '0;

endpackage

// File: hw/rtl/svfs_step.sv
// svfs_step: combinational next-state and result for one tick or start word.
// Depends on svfs_pkg.
module svfs_step (
  input  svfs_pkg::svfs_cfg_t    cfg_i,
  input  svfs_pkg::svfs_state_t  state_i,
  input  svfs_pkg::svfs_item_t   item_i,
  output svfs_pkg::svfs_state_t  state_o,
  output svfs_pkg::svfs_result_t result_o
);
  import svfs_pkg::*;

  // Close everything down; only the first cause of a fill sticks.
  function automatic svfs_state_t finish(input svfs_state_t st, input end_cause_t why);
    svfs_state_t r;
    r = st;
    if (st.running) begin
      r.running      = 1'b0;
      r.established  = 1'b0;
      r.stage        = 2'd0;
      r.valve        = VALVE_NONE;
      r.watch_active = 1'b0;
      r.cause        = why;
    end
    return r;
  endfunction

  function automatic svfs_state_t counter_pulse(input svfs_state_t st, input logic req);
    svfs_state_t r;
    r = st;
    if (req) r.pulse_active = 1'b1;
    if (r.pulse_active) begin
      r.pulse_ticks = r.pulse_ticks + 5'd1;
      if (r.pulse_ticks >= PULSE_TICKS) begin
        r.pulse_active = 1'b0;
        r.pulse_ticks  = 5'd0;
      end
    end
    return r;
  endfunction

  svfs_state_t s;
  logic [15:0] thr;
  logic [2:0]  stage_bit;
  logic [2:0]  sol_pattern;
  logic        slow;

  always_comb begin
    s           = state_i;
    thr         = '0;
    stage_bit   = VALVE_NONE;
    sol_pattern = VALVE_NONE;
    slow        = 1'b0;

    if (item_i.req_type == REQ_START) begin
      s.stage        = 2'd1;
      s.running      = 1'b1;
      s.established  = 1'b0;
      s.settle_count = '0;
      s.settle_done  = 1'b0;
      s.hold_count   = '0;
      s.tick_count   = '0;
      s.slow_count   = '0;
      s.wait_units   = '0;
      s.excess_count = '0;
      s.watch_active = 1'b1;
      s.watch_ticks  = '0;
      s.watch_units  = '0;
      s.cause        = CAUSE_NONE;
      s.valve        = cfg_i.actuator_mode ? VALVE_HIGH : VALVE_ALL;
      s = counter_pulse(s, item_i.counter_request);
    end else begin
      if (s.running) begin
        if (item_i.flow_established) s.established = 1'b1;
        if (item_i.flow_pulse_seen)  s.watch_active = 1'b0;
      end
      if (item_i.switch_on) begin
        if (s.established) begin
          // stage logic
          case (s.stage)
            2'd1: begin
              thr = cfg_i.stage1_threshold; stage_bit = VALVE_LOW;  sol_pattern = 3'b001;
            end
            2'd2: begin
              thr = cfg_i.stage2_threshold; stage_bit = VALVE_MED;  sol_pattern = 3'b011;
            end
            2'd3: begin
              thr = cfg_i.stage3_threshold; stage_bit = VALVE_HIGH; sol_pattern = 3'b111;
            end
            default: begin
              thr = '0; stage_bit = VALVE_NONE; sol_pattern = VALVE_NONE;
            end
          endcase
          slow = item_i.measured_period > thr;

          if (s.stage != 2'd0) begin
            if (cfg_i.actuator_mode) begin
              if (!s.settle_done) begin
                s.settle_count = s.settle_count + 7'd1;
                case (s.stage)
                  2'd1:    s.valve = (s.valve | VALVE_LOW)  & ~VALVE_HIGH;
                  2'd2:    s.valve = (s.valve | VALVE_MED)  & ~VALVE_LOW;
                  default: s.valve = (s.valve | VALVE_HIGH) & ~VALVE_MED;
                endcase
                if (s.settle_count >= SETTLE_TICKS) begin
                  s.settle_count = '0;
                  s.settle_done  = 1'b1;
                end
              end
              if (s.settle_done) begin
                if (!slow) begin
                  s.valve      = s.valve | stage_bit;
                  s.hold_count = '0;
                  if (s.stage == 2'd3) s.slow_count = '0;
                end else if (s.stage == 2'd3) begin
                  if (s.slow_count < SLOW_MAX) s.slow_count = s.slow_count + 6'd1;
                end else begin
                  s.hold_count = s.hold_count + 5'd1;
                  if (s.hold_count >= ACT_HOLD_TICKS) begin
                    s.stage        = s.stage + 2'd1;
                    s.settle_count = '0;
                    s.settle_done  = 1'b0;
                    s.hold_count   = '0;
                  end
                end
              end
            end else begin
              if (!slow) begin
                s.valve      = sol_pattern;
                s.hold_count = '0;
                if (s.stage == 2'd3) s.slow_count = '0;
              end else if (s.stage == 2'd3) begin
                if (s.slow_count < SLOW_MAX) s.slow_count = s.slow_count + 6'd1;
              end else begin
                s.hold_count = s.hold_count + 5'd1;
                if (s.hold_count >= SOL_HOLD_TICKS) begin
                  s.stage      = s.stage + 2'd1;
                  s.hold_count = '0;
                end
              end
            end
          end

          // excess flow, count never clears on a slow period
          if (cfg_i.cutoff_enable && (item_i.measured_period < cfg_i.cutoff_threshold)) begin
            s.excess_count = s.excess_count + 6'd1;
            if (s.excess_count >= UNIT_TICKS) begin
              s.excess_count = '0;
              s = finish(s, CAUSE_EXCESS);
            end
          end

          // wait timeout in 40-tick units
          s.tick_count = s.tick_count + 6'd1;
          if ((s.tick_count >= UNIT_TICKS) || (s.slow_count >= UNIT_TICKS)) begin
            if (s.wait_units < UNITS_MAX) s.wait_units = s.wait_units + 8'd1;
            s.tick_count = '0;
            s.slow_count = '0;
            if (s.wait_units >= cfg_i.wait_limit) begin
              s.wait_units = '0;
              s = finish(s, CAUSE_WAIT);
            end
          end
        end

        s = counter_pulse(s, item_i.counter_request);

        if (s.watch_active) begin
          s.watch_ticks = s.watch_ticks + 6'd1;
          if (s.watch_ticks >= UNIT_TICKS) begin
            s.watch_ticks = '0;
            if (s.watch_units < UNITS_MAX) s.watch_units = s.watch_units + 8'd1;
            if (s.watch_units >= cfg_i.no_flow_limit) begin
              s.watch_active = 1'b0;
              s = finish(s, CAUSE_NO_FLOW);
            end
          end
        end
      end else begin
        s = finish(s, CAUSE_SWITCH_OFF);
        s = counter_pulse(s, item_i.counter_request);
      end
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.low_valve_on       = s.valve[0];
    result_o.med_valve_on       = s.valve[1];
    result_o.high_valve_on      = s.valve[2];
    result_o.fill_stage         = s.stage;
    result_o.fill_active        = s.running;
    result_o.end_cause          = s.cause;
    result_o.counter_drive      = s.pulse_active;
    result_o.pulse_watch_enable = s.running;
  end

endmodule

// File: hw/rtl/staged_valve_fill_sequencer.sv
// staged_valve_fill_sequencer: three-stage gas fill valve sequencer, one word per tick.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless out_stall holds a result; state updates once per word.
// Reset (rst_n low, synchronous): fill idle, valves closed, counters and config cleared.
// Depends on svfs_pkg and svfs_step.
module staged_valve_fill_sequencer (
  input  logic        clk,
  input  logic        rst_n,

  // config write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic        in_switch_on,
  input  logic [15:0] in_measured_period,
  input  logic        in_flow_established,
  input  logic        in_flow_pulse_seen,
  input  logic        in_counter_request,

  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_low_valve_on,
  output logic        out_med_valve_on,
  output logic        out_high_valve_on,
  output logic [1:0]  out_fill_stage,
  output logic        out_fill_active,
  output logic [2:0]  out_end_cause,
  output logic        out_counter_drive,
  output logic        out_pulse_watch_enable
);
  import svfs_pkg::*;

  svfs_cfg_t    cfg_r;
  svfs_state_t  state_r, state_nxt;
  svfs_item_t   item_r;
  logic         item_valid_r;
  svfs_result_t res_r, res_nxt;
  logic         out_valid_r;

  logic out_free;
  logic advance;

  // Config registers, not guarded: the host must write them only while the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STAGE1_THR:   cfg_r.stage1_threshold <= cfg_wdata;
        CFG_STAGE2_THR:   cfg_r.stage2_threshold <= cfg_wdata;
        CFG_STAGE3_THR:   cfg_r.stage3_threshold <= cfg_wdata;
        CFG_CUTOFF_EN:    cfg_r.cutoff_enable    <= cfg_wdata[0];
        CFG_CUTOFF_THR:   cfg_r.cutoff_threshold <= cfg_wdata;
        CFG_WAIT_LIMIT:   cfg_r.wait_limit       <= cfg_wdata[7:0];
        CFG_NOFLOW_LIMIT: cfg_r.no_flow_limit    <= cfg_wdata[7:0];
        CFG_ACT_MODE:     cfg_r.actuator_mode    <= cfg_wdata[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // The result register is free when empty or being taken this cycle.
  // The input register moves into it whenever it is free, so the input
  // side only stalls when a result is held back and a word is waiting.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.req_type         <= in_req_type;
      item_r.switch_on        <= in_switch_on;
      item_r.measured_period  <= in_measured_period;
      item_r.flow_established <= in_flow_established;
      item_r.flow_pulse_seen  <= in_flow_pulse_seen;
      item_r.counter_request  <= in_counter_request;
    end
  end

  // One tick of sequencer work: stage compare, timers, shutdown causes.
  svfs_step u_step (
    .cfg_i    (cfg_r),
    .state_i  (state_r),
    .item_i   (item_r),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  // Sequencer state commits together with the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_low_valve_on       = res_r.low_valve_on;
  assign out_med_valve_on       = res_r.med_valve_on;
  assign out_high_valve_on      = res_r.high_valve_on;
  assign out_fill_stage         = res_r.fill_stage;
  assign out_fill_active        = res_r.fill_active;
  assign out_end_cause          = res_r.end_cause;
  assign out_counter_drive      = res_r.counter_drive;
  assign out_pulse_watch_enable = res_r.pulse_watch_enable;

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for staged_valve_fill_sequencer.
// A queue-fed driver and a checking monitor run against a behavioral fill predictor.
// Depends on svfs_pkg and the staged_valve_fill_sequencer RTL.
module tb_top;
  import svfs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic        in_switch_on = 1'b0;
  logic [15:0] in_measured_period = '0;
  logic        in_flow_established = 1'b0;
  logic        in_flow_pulse_seen = 1'b0;
  logic        in_counter_request = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_low_valve_on;
  logic        out_med_valve_on;
  logic        out_high_valve_on;
  logic [1:0]  out_fill_stage;
  logic        out_fill_active;
  logic [2:0]  out_end_cause;
  logic        out_counter_drive;
  logic        out_pulse_watch_enable;

  staged_valve_fill_sequencer dut (.*);

  always #5 clk = ~clk;

  // Words waiting to be offered, and status words the predictor says must come back.
  svfs_item_t   word_backlog[$];
  svfs_result_t predicted_status[$];
  int           miss_count = 0;
  bit           calm = 1'b0;   // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Fill predictor: the bench's own copy of the registers and sequencer state.
  // ---------------------------------------------------------------------------
  svfs_cfg_t   regs = '0;
  svfs_state_t fill = STATE_RESET;

  // Any end closes every valve and drops the no-flow watch; only the first
  // cause of a fill sticks, since a closed fill is no longer running.
  function automatic void close_fill(end_cause_t why);
    if (fill.running) begin
      fill.running     = 1'b0;
      fill.established = 1'b0;
      fill.stage       = 2'd0;
      fill.valve       = VALVE_NONE;
      fill.watch_active = 1'b0;
      fill.cause       = why;
    end
  endfunction

  // Counter pulse: a request during a running pulse just merges into it.
  function automatic void pulse_tick(logic req);
    if (req) fill.pulse_active = 1'b1;
    if (fill.pulse_active) begin
      fill.pulse_ticks = fill.pulse_ticks + 5'd1;
      if (fill.pulse_ticks >= PULSE_TICKS) begin
        fill.pulse_active = 1'b0;
        fill.pulse_ticks  = 5'd0;
      end
    end
  endfunction

  // One stage decision; a period above the stage threshold means slow flow.
  function automatic void stage_tick(logic [15:0] period);
    logic [15:0] thr;
    logic [2:0]  own_valve;
    if (fill.stage != 2'd0) begin
      thr = (fill.stage == 2'd1) ? regs.stage1_threshold :
            (fill.stage == 2'd2) ? regs.stage2_threshold : regs.stage3_threshold;
      own_valve = (fill.stage == 2'd1) ? VALVE_LOW :
                  (fill.stage == 2'd2) ? VALVE_MED : VALVE_HIGH;
      if (regs.actuator_mode) begin
        // actuator: move valves toward the stage, then wait out the settling time
        if (!fill.settle_done) begin
          fill.settle_count = fill.settle_count + 7'd1;
          case (fill.stage)
            2'd1: fill.valve = (fill.valve | VALVE_LOW) & ~VALVE_HIGH;
            2'd2: fill.valve = (fill.valve | VALVE_MED) & ~VALVE_LOW;
            default: fill.valve = (fill.valve | VALVE_HIGH) & ~VALVE_MED;
          endcase
          if (fill.settle_count >= SETTLE_TICKS) begin
            fill.settle_count = 7'd0;
            fill.settle_done  = 1'b1;
          end
        end
        if (fill.settle_done) begin
          if (period <= thr) begin
            fill.valve      = fill.valve | own_valve;
            fill.hold_count = 5'd0;
            if (fill.stage == 2'd3) fill.slow_count = 6'd0;
          end else if (fill.stage == 2'd3) begin
            if (fill.slow_count < SLOW_MAX) fill.slow_count = fill.slow_count + 6'd1;
          end else begin
            fill.hold_count = fill.hold_count + 5'd1;
            if (fill.hold_count >= ACT_HOLD_TICKS) begin
              fill.stage        = fill.stage + 2'd1;
              fill.settle_count = 7'd0;
              fill.settle_done  = 1'b0;
              fill.hold_count   = 5'd0;
            end
          end
        end
      end else begin
        // solenoid: valves open cumulatively with the stage, no settling
        if (period <= thr) begin
          fill.valve = (fill.stage == 2'd1) ? VALVE_LOW :
                       (fill.stage == 2'd2) ? (VALVE_LOW | VALVE_MED) : VALVE_ALL;
          fill.hold_count = 5'd0;
          if (fill.stage == 2'd3) fill.slow_count = 6'd0;
        end else if (fill.stage == 2'd3) begin
          if (fill.slow_count < SLOW_MAX) fill.slow_count = fill.slow_count + 6'd1;
        end else begin
          fill.hold_count = fill.hold_count + 5'd1;
          if (fill.hold_count >= SOL_HOLD_TICKS) begin
            fill.stage      = fill.stage + 2'd1;
            fill.hold_count = 5'd0;
          end
        end
      end
    end
  endfunction

  // Advances the predictor by one accepted word and returns the status word.
  function automatic svfs_result_t advance_fill(svfs_item_t w);
    logic       keep_active;
    logic [4:0] keep_ticks;
    if (w.req_type == REQ_START) begin
      // start (or restart): everything but the counter pulse begins afresh
      keep_active = fill.pulse_active;
      keep_ticks  = fill.pulse_ticks;
      fill = STATE_RESET;
      fill.pulse_active = keep_active;
      fill.pulse_ticks  = keep_ticks;
      fill.stage        = 2'd1;
      fill.running      = 1'b1;
      fill.watch_active = 1'b1;
      fill.valve        = regs.actuator_mode ? VALVE_HIGH : VALVE_ALL;
      pulse_tick(w.counter_request);
    end else begin
      if (fill.running) begin
        if (w.flow_established) fill.established = 1'b1;
        if (w.flow_pulse_seen) fill.watch_active = 1'b0;
      end
      if (w.switch_on) begin
        if (fill.established) begin
          stage_tick(w.measured_period);
          // excess flow count never clears on a slow period
          if (regs.cutoff_enable && w.measured_period < regs.cutoff_threshold) begin
            fill.excess_count = fill.excess_count + 6'd1;
            if (fill.excess_count >= UNIT_TICKS) begin
              fill.excess_count = 6'd0;
              close_fill(CAUSE_EXCESS);
            end
          end
          fill.tick_count = fill.tick_count + 6'd1;
          if (fill.tick_count >= UNIT_TICKS || fill.slow_count >= UNIT_TICKS) begin
            if (fill.wait_units < UNITS_MAX) fill.wait_units = fill.wait_units + 8'd1;
            fill.tick_count = 6'd0;
            fill.slow_count = 6'd0;
            if (fill.wait_units >= regs.wait_limit) begin
              fill.wait_units = 8'd0;
              close_fill(CAUSE_WAIT);
            end
          end
        end
        pulse_tick(w.counter_request);
        if (fill.watch_active) begin
          fill.watch_ticks = fill.watch_ticks + 6'd1;
          if (fill.watch_ticks >= UNIT_TICKS) begin
            fill.watch_ticks = 6'd0;
            if (fill.watch_units < UNITS_MAX) fill.watch_units = fill.watch_units + 8'd1;
            if (fill.watch_units >= regs.no_flow_limit) begin
              fill.watch_active = 1'b0;
              close_fill(CAUSE_NO_FLOW);
            end
          end
        end
      end else begin
        close_fill(CAUSE_SWITCH_OFF);
        pulse_tick(w.counter_request);
      end
    end
    return {fill.valve[0], fill.valve[1], fill.valve[2], fill.stage, fill.running,
            fill.cause, fill.pulse_active, fill.running};
  endfunction

  function automatic string fmt_status(svfs_result_t s);
    return $sformatf("low=%b med=%b high=%b stage=%0d active=%b cause=%0d cnt=%b watch=%b",
                     s.low_valve_on, s.med_valve_on, s.high_valve_on, s.fill_stage,
                     s.fill_active, s.end_cause, s.counter_drive, s.pulse_watch_enable);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers backlog words; a stalled word is held unchanged. The accepted
  // word is run through the predictor at the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    svfs_item_t taken;
    svfs_item_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = {in_req_type, in_switch_on, in_measured_period, in_flow_established,
                 in_flow_pulse_seen, in_counter_request};
        predicted_status.push_back(advance_fill(taken));
      end
      if (!in_valid || !in_stall) begin
        if (word_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
          next_word = word_backlog.pop_front();
          {in_req_type, in_switch_on, in_measured_period, in_flow_established,
           in_flow_pulse_seen, in_counter_request} <= next_word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, and every accepted status word is checked
  // field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_status
    svfs_result_t got;
    svfs_result_t want;
    string        bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 37);
      if (out_valid && !out_stall) begin
        got = {out_low_valve_on, out_med_valve_on, out_high_valve_on, out_fill_stage,
               out_fill_active, out_end_cause, out_counter_drive, out_pulse_watch_enable};
        if (predicted_status.size() == 0) begin
          miss_count++;
          if (miss_count <= 10) $display("unexpected status word: %s", fmt_status(got));
        end else begin
          want = predicted_status.pop_front();
          bad = "";
          if (got.low_valve_on !== want.low_valve_on) bad = {bad, " low_valve_on"};
          if (got.med_valve_on !== want.med_valve_on) bad = {bad, " med_valve_on"};
          if (got.high_valve_on !== want.high_valve_on) bad = {bad, " high_valve_on"};
          if (got.fill_stage !== want.fill_stage) bad = {bad, " fill_stage"};
          if (got.fill_active !== want.fill_active) bad = {bad, " fill_active"};
          if (got.end_cause !== want.end_cause) bad = {bad, " end_cause"};
          if (got.counter_drive !== want.counter_drive) bad = {bad, " counter_drive"};
          if (got.pulse_watch_enable !== want.pulse_watch_enable)
            bad = {bad, " pulse_watch_enable"};
          if (bad != "") begin
            miss_count++;
            if (miss_count <= 10)
              $display("status mismatch on%s\n  expected %s\n  actual   %s",
                       bad, fmt_status(want), fmt_status(got));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(req_type_t req, bit sw, logic [15:0] period, bit est, bit pls,
                          bit creq);
    word_backlog.push_back({req, sw, period, est, pls, creq});
  endtask

  // Waits until every queued word is in and every status word is back, then
  // lets the pipeline run dry.
  task automatic wait_drained();
    while (word_backlog.size() != 0 || predicted_status.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_STAGE1_THR:   regs.stage1_threshold = val;
      CFG_STAGE2_THR:   regs.stage2_threshold = val;
      CFG_STAGE3_THR:   regs.stage3_threshold = val;
      CFG_CUTOFF_EN:    regs.cutoff_enable    = val[0];
      CFG_CUTOFF_THR:   regs.cutoff_threshold = val;
      CFG_WAIT_LIMIT:   regs.wait_limit       = val[7:0];
      CFG_NOFLOW_LIMIT: regs.no_flow_limit    = val[7:0];
      default:          regs.actuator_mode    = val[0];
    endcase
  endtask

  // Only called with the block idle.
  task automatic load_settings(int t1, int t2, int t3, int cut_en, int cut_thr,
                               int wait_lim, int noflow_lim, int act);
    write_reg(CFG_STAGE1_THR, t1[15:0]);
    write_reg(CFG_STAGE2_THR, t2[15:0]);
    write_reg(CFG_STAGE3_THR, t3[15:0]);
    write_reg(CFG_CUTOFF_EN, cut_en[15:0]);
    write_reg(CFG_CUTOFF_THR, cut_thr[15:0]);
    write_reg(CFG_WAIT_LIMIT, wait_lim[15:0]);
    write_reg(CFG_NOFLOW_LIMIT, noflow_lim[15:0]);
    write_reg(CFG_ACT_MODE, act[15:0]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly complete fills (start, then a run of ticks with the switch on and
  // flow established) so the stages, timeouts and cutoff all get reached;
  // the rest is short bursts of fully random words. With pause_mid set the
  // sender stops halfway through the phase until every status word is back.
  task automatic run_phase(int budget, bit pause_mid);
    int          done_cnt;
    int          len;
    int          k;
    int          slow_pct;
    int          pulse_pct;
    int          est_at;
    int          top;
    int          r;
    int          s;
    logic [15:0] p;
    bit          paused;
    done_cnt = 0;
    paused = 1'b0;
    while (done_cnt < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 460) : $urandom_range(10, 160);
        est_at = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: slow_pct = 30;
          1: slow_pct = 70;
          2: slow_pct = 97;
          default: slow_pct = 100;
        endcase
        case ($urandom_range(0, 3))
          0, 1: pulse_pct = 0;
          2: pulse_pct = 3;
          default: pulse_pct = 40;
        endcase
        top = int'(regs.stage1_threshold);
        if (regs.stage2_threshold > top) top = int'(regs.stage2_threshold);
        if (regs.stage3_threshold > top) top = int'(regs.stage3_threshold);
        add_word(REQ_START, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        done_cnt++;
        for (k = 0; k < len && done_cnt < budget; k++) begin
          r = $urandom_range(0, 99);
          if (r < slow_pct) begin
            // slower than every stage threshold, where that is possible
            p = (top + 16 > 65535) ? 16'hFFFF : 16'(top + $urandom_range(1, 16));
          end else begin
            case ($urandom_range(0, 2))
              0: p = (regs.cutoff_threshold == 0) ? 16'd0 :
                     16'($urandom_range(0, regs.cutoff_threshold - 1));
              1: p = 16'($urandom_range(0, 65535));
              default: begin
                s = $urandom_range(1, 3);
                p = (s == 1) ? regs.stage1_threshold :
                    (s == 2) ? regs.stage2_threshold : regs.stage3_threshold;
                if ($urandom_range(0, 1) && p != 16'hFFFF) p = p + 16'd1;
              end
            endcase
          end
          add_word(REQ_TICK, $urandom_range(0, 299) != 0, p,
                   (k >= est_at) && ($urandom_range(0, 3) != 0),
                   $urandom_range(0, 99) < pulse_pct, $urandom_range(0, 29) == 0);
          done_cnt++;
          if (pause_mid && !paused && done_cnt >= budget / 2) begin
            paused = 1'b1;
            wait_drained();
          end
        end
      end else begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len && done_cnt < budget; k++) begin
          add_word(($urandom_range(0, 4) == 0) ? REQ_START : REQ_TICK,
                   $urandom_range(0, 4) != 0, 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          done_cnt++;
          if (pause_mid && !paused && done_cnt >= budget / 2) begin
            paused = 1'b1;
            wait_drained();
          end
        end
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: solenoid valves, cutoff on, short timeouts.
    load_settings(100, 200, 300, 1, 50, 2, 1, 0);
    add_word(REQ_TICK,  1'b0, 16'd0,     1'b0, 1'b0, 1'b1); // idle tick, counter pulse starts
    add_word(REQ_TICK,  1'b1, 16'd0,     1'b1, 1'b1, 1'b1); // flow inputs ignored when idle; merge
    add_word(REQ_START, 1'b0, 16'hFFFF,  1'b1, 1'b1, 1'b0); // start ignores switch and flow
    add_word(REQ_TICK,  1'b1, 16'hFFFF,  1'b0, 1'b0, 1'b0); // not established yet
    add_word(REQ_TICK,  1'b1, 16'd0,     1'b1, 1'b0, 1'b0); // established, excess period
    add_word(REQ_TICK,  1'b1, 16'hFFFF,  1'b0, 1'b0, 1'b0); // slow period, excess count kept
    add_word(REQ_TICK,  1'b1, 16'd0,     1'b0, 1'b0, 1'b1);
    add_word(REQ_START, 1'b1, 16'd0,     1'b0, 1'b0, 1'b1); // restart during a running fill
    add_word(REQ_TICK,  1'b1, 16'd100,   1'b1, 1'b1, 1'b0); // period right at the threshold
    add_word(REQ_TICK,  1'b1, 16'd101,   1'b0, 1'b0, 1'b0); // one above it
    add_word(REQ_TICK,  1'b1, 16'd49,    1'b0, 1'b0, 1'b0); // just under the cutoff
    add_word(REQ_TICK,  1'b1, 16'd50,    1'b0, 1'b0, 1'b0); // at the cutoff
    add_word(REQ_TICK,  1'b0, 16'hAAAA,  1'b0, 1'b0, 1'b0); // switch off ends the fill
    add_word(REQ_TICK,  1'b0, 16'h5555,  1'b1, 1'b1, 1'b1); // already ended, cause holds
    add_word(REQ_TICK,  1'b1, 16'd0,     1'b1, 1'b1, 1'b0); // ended: flow ignored
    add_word(REQ_START, 1'b1, 16'hFFFF,  1'b1, 1'b1, 1'b1);
    add_word(REQ_TICK,  1'b1, 16'hFFFF,  1'b1, 1'b1, 1'b1);
    wait_drained();

    // Solenoid, tight cutoff and waits; the sender pauses mid-phase once.
    load_settings($urandom_range(0, 4000), $urandom_range(0, 4000), $urandom_range(0, 4000),
                  1, $urandom_range(0, 500), 8, 3, 0);
    run_phase(360, 1'b1);

    // Actuator with settling, no cutoff, longest no-flow limit; nobody idles here.
    calm = 1'b1;
    load_settings($urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(0, 3000),
                  0, 0, 12, 255, 1);
    run_phase(400, 1'b0);
    calm = 1'b0;

    // Top extremes: nothing is ever slow, nearly everything is excess.
    load_settings(65535, 65535, 65535, 1, 65535, 255, 0, 1);
    run_phase(250, 1'b0);

    // Bottom extremes: every register zero.
    load_settings(0, 0, 0, 0, 0, 0, 0, 0);
    run_phase(250, 1'b0);

    repeat (2) begin
      load_settings($urandom_range(0, 20000), $urandom_range(0, 20000),
                    $urandom_range(0, 20000), $urandom_range(0, 1), $urandom_range(0, 3000),
                    $urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 1));
      run_phase(270, 1'b0);
    end

    repeat (10) @(posedge clk);
    if (miss_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
